>>> src/assert_macros.svh
// Assertion macros used by the checker file of the heartbeat monitor.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heartbeat monitor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heartbeat monitor assertion failed");

`endif

>>> src/hbm_pkg.sv
// Shared types and constants for the multi-core heartbeat monitor.
// Depends on nothing; used by every module of the block.
package hbm_pkg;

    localparam int MAX_CORES = 64;
    localparam int AW        = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNT_W     = $clog2(MAX_CORES + 1);
    localparam int IDX_W     = 6;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_REGISTER = 2'd1,
        ACT_ALIVE    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_MISSING = 2'd0,
        ST_ALIVE   = 2'd1,
        ST_DEAD    = 2'd2,
        ST_GONE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_WALK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] core_index;
    } hbm_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] failed_core;
        logic             last_failure;
    } hbm_rsp_t;

    typedef struct packed {
        logic    active;
        status_t status;
    } hbm_entry_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        hbm_entry_t    data;
    } hbm_wr_t;

endpackage

>>> src/hbm_table.sv
// Per-core table: active mark and status in a memory with registered read.
// Depends on hbm_pkg; entries never written read as inactive and missing.
module hbm_table (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [hbm_pkg::AW-1:0]   rd_addr,
    input  hbm_pkg::hbm_wr_t         wr,
    output hbm_pkg::hbm_entry_t      rd_entry
);

    hbm_pkg::hbm_entry_t              mem [hbm_pkg::MAX_CORES];
    logic [hbm_pkg::MAX_CORES-1:0]    vld_reg;
    hbm_pkg::hbm_entry_t              rd_data_reg;
    logic                             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> src/multi_core_heartbeat_monitor.sv
// Register and alive requests read and rewrite their entry; unused actions need no
// table access. A tick walks every table entry, one per cycle through the single read
// port unless the result side stalls. The block accepts one request at a time.
// Reset (rst_n, asynchronous) marks all cores inactive and missing and
// enables failure reporting. Top level; depends on hbm_pkg and hbm_table.
module multi_core_heartbeat_monitor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hbm_pkg::hbm_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hbm_pkg::hbm_rsp_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    hbm_pkg::state_t                state_reg, state_next;
    logic                           enable_reg;
    logic                           op_alive_reg, op_alive_next;
    logic [hbm_pkg::AW-1:0]         op_idx_reg, op_idx_next;
    logic [hbm_pkg::CNT_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                           proc_vld_reg, proc_vld_next;
    logic [hbm_pkg::AW-1:0]         proc_idx_reg, proc_idx_next;
    logic                           pend_vld_reg, pend_vld_next;
    logic [hbm_pkg::AW-1:0]         pend_idx_reg, pend_idx_next;
    logic                           out_valid_reg, out_valid_next;
    hbm_pkg::hbm_rsp_t              out_data_reg, out_data_next;

    logic                           rd_en;
    logic [hbm_pkg::AW-1:0]         rd_addr;
    hbm_pkg::hbm_wr_t               wr;
    hbm_pkg::hbm_entry_t            rd_entry;

    logic                           in_range;
    logic                           is_tick;
    logic                           is_op;
    logic                           issue_done;
    logic                           out_free;
    logic                           adv;
    logic                           fail;

    hbm_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

    assign in_range   = 32'(in_data.core_index) < hbm_pkg::MAX_CORES;
    assign is_tick    = in_data.action == hbm_pkg::ACT_TICK;
    assign is_op      = (in_data.action == hbm_pkg::ACT_REGISTER ||
                         in_data.action == hbm_pkg::ACT_ALIVE) && in_range;
    assign issue_done = issue_cnt_reg == hbm_pkg::CNT_W'(hbm_pkg::MAX_CORES);
    assign out_free   = !out_valid_reg || out_ready;
    assign adv        = !pend_vld_reg || out_free;

    assign in_ready  = state_reg == hbm_pkg::S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbm_pkg::S_IDLE:
            begin
                if (in_valid && is_tick)
                begin
                    state_next = hbm_pkg::S_WALK;
                end
                else if (in_valid && is_op)
                begin
                    state_next = hbm_pkg::S_OP;
                end
            end
            hbm_pkg::S_OP:
            begin
                state_next = hbm_pkg::S_IDLE;
            end
            hbm_pkg::S_WALK:
            begin
                if (issue_done && !proc_vld_reg)
                begin
                    state_next = hbm_pkg::S_FLUSH;
                end
            end
            hbm_pkg::S_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = hbm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hbm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = issue_cnt_reg[hbm_pkg::AW-1:0];
        wr             = '0;
        fail           = 1'b0;
        op_alive_next  = op_alive_reg;
        op_idx_next    = op_idx_reg;
        issue_cnt_next = issue_cnt_reg;
        proc_vld_next  = proc_vld_reg;
        proc_idx_next  = proc_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            hbm_pkg::S_IDLE:
            begin
                if (in_valid && is_tick)
                begin
                    issue_cnt_next = '0;
                    proc_vld_next  = 1'b0;
                end
                else if (in_valid && is_op)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = hbm_pkg::AW'(in_data.core_index);
                    op_idx_next   = hbm_pkg::AW'(in_data.core_index);
                    op_alive_next = in_data.action == hbm_pkg::ACT_ALIVE;
                end
            end
            hbm_pkg::S_OP:
            begin
                wr.en   = 1'b1;
                wr.addr = op_idx_reg;
                if (op_alive_reg)
                begin
                    wr.data.active = rd_entry.active;
                    wr.data.status = hbm_pkg::ST_ALIVE;
                end
                else
                begin
                    wr.data.active = 1'b1;
                    wr.data.status = rd_entry.status;
                end
            end
            hbm_pkg::S_WALK:
            begin
                if (adv)
                begin
                    if (!issue_done)
                    begin
                        rd_en          = 1'b1;
                        proc_vld_next  = 1'b1;
                        proc_idx_next  = issue_cnt_reg[hbm_pkg::AW-1:0];
                        issue_cnt_next = issue_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        proc_vld_next = 1'b0;
                    end
                    if (proc_vld_reg && rd_entry.active)
                    begin
                        wr.addr        = proc_idx_reg;
                        wr.data.active = 1'b1;
                        case (rd_entry.status)
                            hbm_pkg::ST_ALIVE:
                            begin
                                wr.en          = 1'b1;
                                wr.data.status = hbm_pkg::ST_MISSING;
                            end
                            hbm_pkg::ST_MISSING:
                            begin
                                wr.en          = 1'b1;
                                wr.data.status = hbm_pkg::ST_DEAD;
                            end
                            hbm_pkg::ST_DEAD:
                            begin
                                wr.en          = 1'b1;
                                wr.data.status = hbm_pkg::ST_GONE;
                                fail           = enable_reg;
                            end
                            default:
                            begin
                                wr.data.status = hbm_pkg::ST_GONE;
                            end
                        endcase
                    end
                    if (fail)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_valid_next             = 1'b1;
                            out_data_next.failed_core  = hbm_pkg::IDX_W'(pend_idx_reg);
                            out_data_next.last_failure = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = proc_idx_reg;
                    end
                end
            end
            hbm_pkg::S_FLUSH:
            begin
                if (pend_vld_reg && out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.failed_core  = hbm_pkg::IDX_W'(pend_idx_reg);
                    out_data_next.last_failure = 1'b1;
                    pend_vld_next              = 1'b0;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbm_pkg::S_IDLE;
            enable_reg    <= 1'b1;
            issue_cnt_reg <= '0;
            proc_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            proc_vld_reg  <= proc_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_alive_reg <= op_alive_next;
        op_idx_reg   <= op_idx_next;
        proc_idx_reg <= proc_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> src/hbm_checker.sv
// Port-level checker for the heartbeat monitor, bound to the top level.
// Depends on hbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hbm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input hbm_pkg::hbm_req_t in_data,
    input logic              out_valid,
    input logic              out_ready,
    input hbm_pkg::hbm_rsp_t out_data
);

    // A result that is not taken stays offered unchanged.
    `HBM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // A tick request occupies the block for its walk.
    `HBM_ASSERT_NXT(a_tick_busy, clk, rst_n, in_valid && in_ready && in_data.action == hbm_pkg::ACT_TICK, !in_ready)

    // A register or alive request keeps the block busy while it updates the table.
    `HBM_ASSERT_NXT(a_op_busy, clk, rst_n, in_valid && in_ready && (in_data.action == hbm_pkg::ACT_REGISTER || in_data.action == hbm_pkg::ACT_ALIVE), !in_ready)

endmodule

bind multi_core_heartbeat_monitor hbm_checker u_hbm_checker (.*);

>>> bench/heartbeat_predictor_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the heartbeat monitor bench. It tracks core activity and status,
// predicts the failure results of each accepted request and checks them in order.
// Depends on hbm_pkg.
package heartbeat_predictor_pkg;

    import hbm_pkg::*;

    class heartbeat_predictor;
        bit          core_active [MAX_CORES];
        status_t     core_status [MAX_CORES];
        bit          report_enable;
        hbm_rsp_t    pending_failures [$];
        int unsigned mismatch_count;
        int unsigned failures_predicted;
        int unsigned ticks_seen;
        int unsigned requests_seen;
        int unsigned enable_writes;

        function new();
            foreach (core_active[i])
            begin
                core_active[i] = 1'b0;
                core_status[i] = ST_MISSING;
            end
            report_enable      = 1'b1;
            mismatch_count     = 0;
            failures_predicted = 0;
            ticks_seen         = 0;
            requests_seen      = 0;
            enable_writes      = 0;
        endfunction

        function void set_report_enable(logic value);
            report_enable = value;
            enable_writes++;
        endfunction

        function void note_request(hbm_req_t req);
            hbm_rsp_t fail;
            int       found;
            found = 0;
            requests_seen++;
            if (req.action == ACT_TICK)
            begin
                ticks_seen++;
                for (int i = 0; i < MAX_CORES; i++)
                begin
                    if (!core_active[i])
                        continue;
                    case (core_status[i])
                        ST_ALIVE:   core_status[i] = ST_MISSING;
                        ST_MISSING: core_status[i] = ST_DEAD;
                        ST_DEAD:
                        begin
                            core_status[i] = ST_GONE;
                            if (report_enable)
                            begin
                                fail.failed_core  = IDX_W'(i);
                                fail.last_failure = 1'b0;
                                pending_failures.push_back(fail);
                                found++;
                            end
                        end
                        default: ;
                    endcase
                end
                if (found > 0)
                    pending_failures[pending_failures.size() - 1].last_failure = 1'b1;
                failures_predicted += found;
            end
            else if (req.action == ACT_REGISTER)
            begin
                if (int'(req.core_index) < MAX_CORES)
                    core_active[req.core_index] = 1'b1;
            end
            else if (req.action == ACT_ALIVE)
            begin
                if (int'(req.core_index) < MAX_CORES)
                    core_status[req.core_index] = ST_ALIVE;
            end
        endfunction

        function void check_result(hbm_rsp_t got);
            hbm_rsp_t want;
            if (pending_failures.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: failure result with none expected: expected nothing, actual core %0d last %0b",
                         $time, got.failed_core, got.last_failure);
                return;
            end
            want = pending_failures.pop_front();
            if (got.failed_core !== want.failed_core)
            begin
                mismatch_count++;
                $display("%0t: failed_core expected %0d actual %0d",
                         $time, want.failed_core, got.failed_core);
            end
            if (got.last_failure !== want.last_failure)
            begin
                mismatch_count++;
                $display("%0t: last_failure expected %0b actual %0b",
                         $time, want.last_failure, got.last_failure);
            end
        endfunction
    endclass

endpackage

>>> bench/tb_multi_core_heartbeat_monitor.sv
`timescale 1ns / 100ps
// Top-level bench for the multi-core heartbeat monitor. It drives directed and random
// requests under varying back-pressure and checks every failure result.
// Depends on hbm_pkg, heartbeat_predictor_pkg and multi_core_heartbeat_monitor.
module tb_multi_core_heartbeat_monitor;

    import hbm_pkg::*;
    import heartbeat_predictor_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         DRAIN_CYCLES   = 2 * MAX_CORES + 8;
    localparam int         WATCHDOG_LIMIT = 4000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    hbm_req_t in_data;
    logic     out_valid;
    logic     out_ready;
    hbm_rsp_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned idle_cycles;

    heartbeat_predictor predictor = new();

    multi_core_heartbeat_monitor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                predictor.check_result(out_data);
            if (cfg_valid && cfg_ready)
                predictor.set_report_enable(cfg_data);
            if (in_valid && in_ready)
                predictor.note_request(in_data);
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic hbm_req_t build_request(logic [1:0] act, int idx);
        hbm_req_t req;
        req.action     = act;
        req.core_index = IDX_W'(idx);
        return req;
    endfunction

    function automatic hbm_req_t random_request();
        hbm_req_t    req;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25)
            req.action = ACT_TICK;
        else if (roll < 55)
            req.action = ACT_REGISTER;
        else if (roll < 92)
            req.action = ACT_ALIVE;
        else
            req.action = ACT_UNUSED;
        if ($urandom_range(1) == 0)
            req.core_index = IDX_W'($urandom_range(7));
        else
            req.core_index = IDX_W'($urandom_range(MAX_CORES - 1));
        return req;
    endfunction

    task automatic send_request(hbm_req_t req);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (predictor.pending_failures.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_enable(logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int unsigned count);
        hbm_req_t    req;
        int unsigned sent;
        sent = 0;
        while (sent < count)
        begin
            req = random_request();
            send_request(req);
            if (req.action != ACT_UNUSED)
                sent++;
            if ($urandom_range(39) == 0)
                wait_for_quiet();
        end
    endtask

    initial
    begin
        int unsigned send_modes [3];
        int unsigned recv_modes [3];
        send_modes = '{8, 52, 0};
        recv_modes = '{52, 8, 0};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_enable(1'b1);
        send_request(build_request(ACT_TICK, 0));
        send_request(build_request(ACT_ALIVE, 5));
        send_request(build_request(ACT_REGISTER, 0));
        send_request(build_request(ACT_REGISTER, MAX_CORES - 1));
        send_request(build_request(ACT_REGISTER, 5));
        send_request(build_request(ACT_REGISTER, 5));
        send_request(build_request(ACT_UNUSED, 0));
        send_request(build_request(ACT_UNUSED, MAX_CORES - 1));
        repeat (4) send_request(build_request(ACT_TICK, 0));
        send_request(build_request(ACT_ALIVE, MAX_CORES - 1));
        send_request(build_request(ACT_ALIVE, 0));
        repeat (2) send_request(build_request(ACT_TICK, 0));
        wait_for_quiet();
        write_enable(1'b0);
        repeat (2) send_request(build_request(ACT_TICK, 0));
        wait_for_quiet();
        write_enable(1'b1);
        send_request(build_request(ACT_ALIVE, 0));
        repeat (3) send_request(build_request(ACT_TICK, 0));

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = send_modes[mode];
            recv_idle = recv_modes[mode];
            wait_for_quiet();
            write_enable(1'b1);
            run_random(50);
            wait_for_quiet();
            write_enable(1'b0);
            run_random(24);
        end
        wait_for_quiet();

        $display("Covered %0d requests with %0d ticks, %0d failure results checked,",
                 predictor.requests_seen, predictor.ticks_seen, predictor.failures_predicted);
        $display("and %0d report-enable writes under three back-pressure mixes.",
                 predictor.enable_writes);
        if (predictor.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
